[hdl/jaaf_pkg.sv]
package jaaf_pkg;

  // Field widths
  localparam int Q_W       = 32;
  localparam int THR_W     = 31;
  localparam int TYPE_W    = 2;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USE_TABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_MYO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_T0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_T1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_T2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_T3   = 3'd6;

  // Fixed-point constants
  localparam logic signed [32:0] MYO_HALF = 33'sd32768;

  // Pipeline stage map
  localparam int ST_A     = 0;
  localparam int ST_B     = 1;
  localparam int ST_C     = 2;
  localparam int ST_SQ0   = 3;
  localparam int SQ_STEPS = 32;
  localparam int ST_DV0   = ST_SQ0 + SQ_STEPS + 1;
  localparam int DV_STEPS = 31;
  localparam int ST_MUL   = ST_DV0 + DV_STEPS + 1;
  localparam int ST_OUT   = ST_MUL + 1;
  localparam int NST      = ST_OUT + 1;

  // Side data that rides along the square-root and divider stages
  typedef struct packed {
    logic signed [Q_W-1:0] f;     // scalar force, Q16.16
    logic                  nx;    // edge dx negative
    logic                  ny;    // edge dy negative
    logic [Q_W-1:0]        ax;    // |dx| after normalizing
    logic [Q_W-1:0]        ay;    // |dy| after normalizing
    logic                  zero;  // zero-length edge
  } carry_t;

endpackage

[hdl/jaaf_in_if.sv]
interface jaaf_in_if;
  import jaaf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [Q_W-1:0]    edge_dx;
  logic signed [Q_W-1:0]    edge_dy;
  logic                     right_outer;
  logic [TYPE_W-1:0]        right_type;
  logic signed [Q_W-1:0]    right_beta;
  logic                     left_outer;
  logic [TYPE_W-1:0]        left_type;
  logic signed [Q_W-1:0]    left_beta;
  logic signed [Q_W-1:0]    myo_here;
  logic signed [Q_W-1:0]    myo_pair;

  modport source (
    output valid, edge_dx, edge_dy, right_outer, right_type, right_beta,
           left_outer, left_type, left_beta, myo_here, myo_pair,
    input  ready
  );
  modport sink (
    input  valid, edge_dx, edge_dy, right_outer, right_type, right_beta,
           left_outer, left_type, left_beta, myo_here, myo_pair,
    output ready
  );
endinterface

[hdl/jaaf_out_if.sv]
interface jaaf_out_if;
  import jaaf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] force_x;
  logic signed [Q_W-1:0] force_y;
  logic                  zero_edge;

  modport source (output valid, force_x, force_y, zero_edge, input ready);
  modport sink (input valid, force_x, force_y, zero_edge, output ready);
endinterface

[hdl/junction_active_area_force.sv]
// Junction active force, Q16.16 fixed point.
// in_ch carries one junction per transfer: edge vector, outer flags, types or own
// coefficients of both cells and the myosin on both half edges. out_ch returns
// one transfer per junction, in order: force_x, force_y and zero_edge.
// Configuration goes through cfg_we / cfg_idx / cfg_data, one register per cycle.
// The user must write it only while the pipeline is empty; nothing enforces it.
// Stages A, B and C do coefficient select, products and normalizing; then come
// 32 stages of restoring square root (one result bit each), 31 stages of
// restoring division (one quotient bit each, both components in parallel),
// a multiply stage and a round/saturate stage.
// Throughput is one junction per cycle while out_ch is not stalled.
// Each stage keeps a valid bit; a stage loads whenever it is empty or the stage
// after it moves, so bubbles collapse and in_ch.ready stays high while any stage
// is empty, even with a result waiting on out_ch. When out_ch is stalled the
// pipeline fills and then holds; nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits and sets the configuration
// to: coefficients from inputs, no myosin centering, threshold 1 LSB, table zero.
module junction_active_area_force import jaaf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  jaaf_in_if.sink              in_ch,
  jaaf_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [Q_W-1:0]       cfg_data
);

  typedef struct packed {
    logic [63:0] op;
    logic [63:0] res;
  } sq_t;

  typedef struct packed {
    logic [63:0] r;
    logic [DV_STEPS-1:0] q;
  } dv_t;

  // one restoring square-root step, s counts from 0
  function automatic sq_t sqrt_step(input sq_t cur, input int s);
    logic [63:0] bitv;
    logic [63:0] t;
    sq_t nxt;
    bitv = 64'd1 << (62 - 2 * s);
    t = cur.res + bitv;
    if (cur.op >= t) begin
      nxt.op  = cur.op - t;
      nxt.res = (cur.res >> 1) + bitv;
    end else begin
      nxt.op  = cur.op;
      nxt.res = cur.res >> 1;
    end
    return nxt;
  endfunction

  // one restoring division step for quotient bit i
  function automatic dv_t div_step(input dv_t cur, input logic [Q_W-1:0] len, input int i);
    logic [63:0] d;
    dv_t nxt;
    d = {32'd0, len} << i;
    nxt = cur;
    if (cur.r >= d) begin
      nxt.r    = cur.r - d;
      nxt.q[i] = 1'b1;
    end
    return nxt;
  endfunction

  function automatic logic [Q_W-1:0] abs32(input logic signed [Q_W-1:0] v);
    return v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
  endfunction

  // ---------------------------------------------------------------- config
  logic                  use_table_r;
  logic                  sym_myo_r;
  logic [THR_W-1:0]      thr_r;
  logic signed [Q_W-1:0] beta_tab_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_table_r <= 1'b0;
      sym_myo_r   <= 1'b0;
      thr_r       <= THR_W'(1);
      for (int i = 0; i < 4; i++) beta_tab_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_USE_TABLE: use_table_r   <= cfg_data[0];
        CFG_SYM_MYO:   sym_myo_r     <= cfg_data[0];
        CFG_THRESHOLD: thr_r         <= cfg_data[THR_W-1:0];
        CFG_BETA_T0:   beta_tab_r[0] <= cfg_data;
        CFG_BETA_T1:   beta_tab_r[1] <= cfg_data;
        CFG_BETA_T2:   beta_tab_r[2] <= cfg_data;
        CFG_BETA_T3:   beta_tab_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_ch.ready;
    for (int k = NST - 2; k >= 0; k--) en[k] = !vld_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_ch.valid;
      for (int k = 1; k < NST; k++) if (en[k]) vld_r[k] <= vld_r[k-1];
    end
  end

  assign in_ch.ready = en[0];

  // ---------------------------------------------------------------- stage A
  // coefficient select, thresholding, myosin centering
  logic signed [Q_W-1:0] a_br_r, a_bl_r, a_dx_r, a_dy_r;
  logic signed [32:0]    a_mr_r, a_ml_r;
  logic                  a_zero_r;
  logic signed [Q_W-1:0] br_sel, bl_sel, br_nxt, bl_nxt;
  logic signed [32:0]    mr_nxt, ml_nxt;

  always_comb begin
    br_sel = use_table_r ? beta_tab_r[in_ch.right_type] : in_ch.right_beta;
    bl_sel = use_table_r ? beta_tab_r[in_ch.left_type]  : in_ch.left_beta;
    br_nxt = in_ch.right_outer ? '0 : br_sel;
    bl_nxt = in_ch.left_outer  ? '0 : bl_sel;
    if (abs32(br_nxt) < {1'b0, thr_r}) bl_nxt = '0;
    if (abs32(bl_nxt) < {1'b0, thr_r}) br_nxt = '0;
    mr_nxt = 33'(in_ch.myo_here);
    ml_nxt = 33'(in_ch.myo_pair);
    if (sym_myo_r) begin
      mr_nxt = mr_nxt - MYO_HALF;
      ml_nxt = ml_nxt - MYO_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_A]) begin
      a_br_r   <= br_nxt;
      a_bl_r   <= bl_nxt;
      a_mr_r   <= mr_nxt;
      a_ml_r   <= ml_nxt;
      a_dx_r   <= in_ch.edge_dx;
      a_dy_r   <= in_ch.edge_dy;
      a_zero_r <= (in_ch.edge_dx == '0) && (in_ch.edge_dy == '0);
    end
  end

  // ---------------------------------------------------------------- stage B
  // coefficient products, nonzero edge normalized so the larger magnitude is in [2^30, 2^31]
  logic signed [64:0] b_pr_r, b_pl_r;
  logic [Q_W-1:0]     b_ax_r, b_ay_r;
  logic               b_nx_r, b_ny_r, b_zero_r;
  logic [Q_W-1:0]     ax_a, ay_a, mx_a;
  logic [4:0]         shamt;

  always_comb begin
    ax_a  = abs32(a_dx_r);
    ay_a  = abs32(a_dy_r);
    mx_a  = (ax_a > ay_a) ? ax_a : ay_a;
    shamt = '0;
    if (!(mx_a[31] || mx_a[30])) begin
      for (int i = 0; i < 30; i++) if (mx_a[i]) shamt = 5'(30 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_B]) begin
      b_pr_r   <= 65'(a_br_r) * 65'(a_mr_r);
      b_pl_r   <= 65'(a_bl_r) * 65'(a_ml_r);
      b_ax_r   <= ax_a << shamt;
      b_ay_r   <= ay_a << shamt;
      b_nx_r   <= a_dx_r[Q_W-1];
      b_ny_r   <= a_dy_r[Q_W-1];
      b_zero_r <= a_zero_r;
    end
  end

  // ---------------------------------------------------------------- stage C
  // scalar force rounded and saturated, squared components
  logic [63:0]        c_sqx_r, c_sqy_r;
  carry_t             c_car_r;
  logic signed [65:0] fdiff, fsh;
  logic signed [Q_W-1:0] f_sat;

  always_comb begin
    fdiff = 66'(b_pr_r) - 66'(b_pl_r) + 66'sd32768;
    fsh   = fdiff >>> 16;
    if (fsh > 66'sd2147483647)       f_sat = 32'sh7fffffff;
    else if (fsh < -66'sd2147483648) f_sat = 32'sh80000000;
    else                             f_sat = fsh[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[ST_C]) begin
      c_sqx_r      <= 64'(b_ax_r) * 64'(b_ax_r);
      c_sqy_r      <= 64'(b_ay_r) * 64'(b_ay_r);
      c_car_r.f    <= f_sat;
      c_car_r.nx   <= b_nx_r;
      c_car_r.ny   <= b_ny_r;
      c_car_r.ax   <= b_ax_r;
      c_car_r.ay   <= b_ay_r;
      c_car_r.zero <= b_zero_r;
    end
  end

  // ---------------------------------------------------------------- square root
  sq_t    sq_r  [SQ_STEPS+1];
  carry_t sqc_r [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (en[ST_SQ0]) begin
      sq_r[0].op  <= c_sqx_r + c_sqy_r;
      sq_r[0].res <= '0;
      sqc_r[0]    <= c_car_r;
    end
    for (int s = 0; s < SQ_STEPS; s++) begin
      if (en[ST_SQ0+s+1]) begin
        sq_r[s+1]  <= sqrt_step(sq_r[s], s);
        sqc_r[s+1] <= sqc_r[s];
      end
    end
  end

  // ---------------------------------------------------------------- division
  // unit components round(a * 2^30 / len), x from |dy| and y from |dx|
  dv_t            dvx_r [DV_STEPS+1];
  dv_t            dvy_r [DV_STEPS+1];
  logic [Q_W-1:0] len_r [DV_STEPS+1];
  carry_t         dvc_r [DV_STEPS+1];
  logic [Q_W-1:0] len_sq;

  assign len_sq = sq_r[SQ_STEPS].res[Q_W-1:0];

  always_ff @(posedge clk) begin
    if (en[ST_DV0]) begin
      dvx_r[0].r <= ({32'd0, sqc_r[SQ_STEPS].ay} << 30) + 64'(len_sq >> 1);
      dvy_r[0].r <= ({32'd0, sqc_r[SQ_STEPS].ax} << 30) + 64'(len_sq >> 1);
      dvx_r[0].q <= '0;
      dvy_r[0].q <= '0;
      len_r[0]   <= len_sq;
      dvc_r[0]   <= sqc_r[SQ_STEPS];
    end
    for (int s = 0; s < DV_STEPS; s++) begin
      if (en[ST_DV0+s+1]) begin
        dvx_r[s+1] <= div_step(dvx_r[s], len_r[s], DV_STEPS - 1 - s);
        dvy_r[s+1] <= div_step(dvy_r[s], len_r[s], DV_STEPS - 1 - s);
        len_r[s+1] <= len_r[s];
        dvc_r[s+1] <= dvc_r[s];
      end
    end
  end

  // ---------------------------------------------------------------- multiply
  logic signed [63:0]    m_px_r, m_py_r;
  logic                  m_zero_r;
  logic signed [Q_W-1:0] qx_s, qy_s, ux, uy;

  always_comb begin
    qx_s = signed'({1'b0, dvx_r[DV_STEPS].q});
    qy_s = signed'({1'b0, dvy_r[DV_STEPS].q});
    // ux carries the sign of -dy, uy the sign of dx
    ux = dvc_r[DV_STEPS].ny ? qx_s : -qx_s;
    uy = dvc_r[DV_STEPS].nx ? -qy_s : qy_s;
  end

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      m_px_r   <= 64'(dvc_r[DV_STEPS].f) * 64'(ux);
      m_py_r   <= 64'(dvc_r[DV_STEPS].f) * 64'(uy);
      m_zero_r <= dvc_r[DV_STEPS].zero;
    end
  end

  // ---------------------------------------------------------------- round, saturate
  logic signed [Q_W-1:0] o_fx_r, o_fy_r, fx_nxt, fy_nxt;
  logic                  o_zero_r;
  logic signed [64:0]    tx, ty;

  always_comb begin
    tx = (65'(m_px_r) + 65'sd536870912) >>> 30;
    ty = (65'(m_py_r) + 65'sd536870912) >>> 30;
    if (tx > 65'sd2147483647)       fx_nxt = 32'sh7fffffff;
    else if (tx < -65'sd2147483648) fx_nxt = 32'sh80000000;
    else                            fx_nxt = tx[Q_W-1:0];
    if (ty > 65'sd2147483647)       fy_nxt = 32'sh7fffffff;
    else if (ty < -65'sd2147483648) fy_nxt = 32'sh80000000;
    else                            fy_nxt = ty[Q_W-1:0];
    if (m_zero_r) begin
      fx_nxt = '0;
      fy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      o_fx_r   <= fx_nxt;
      o_fy_r   <= fy_nxt;
      o_zero_r <= m_zero_r;
    end
  end

  assign out_ch.valid     = vld_r[ST_OUT];
  assign out_ch.force_x   = o_fx_r;
  assign out_ch.force_y   = o_fy_r;
  assign out_ch.zero_edge = o_zero_r;

`ifndef SYNTHESIS
  // a zero-length edge never carries force
  a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_edge |-> out_ch.force_x == '0 && out_ch.force_y == '0)
    else $error("force on zero-length edge");

  // a free output lets the whole pipeline move
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output is free");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

  // a held result keeps the input side open only if some stage is empty
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r) && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken into a full stalled pipeline");
`endif

endmodule

[verif/junction_active_area_force_checker.sv]
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts the force of every
// junction that goes in and compares it with what comes out, in order.
module junction_active_area_force_checker import jaaf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  jaaf_in_if                   in_ch,
  jaaf_out_if                  out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [Q_W-1:0]       cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   n_checked,
  output int                   n_zero_edge
);

  typedef struct {
    logic signed [Q_W-1:0] fx;
    logic signed [Q_W-1:0] fy;
    logic                  zero;
  } force_t;

  // shadow of the block's registers
  logic                  use_table;
  logic                  sym_myo;
  logic [THR_W-1:0]      thresh;
  logic signed [Q_W-1:0] beta_tab [4];

  force_t force_q [$];

  function automatic longint sat_q(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint iabs(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // floor square root, one result bit per pass
  function automatic bit [63:0] root_floor(input bit [63:0] x);
    bit [63:0] op, res, b;
    op = x;
    res = 0;
    b = 64'd1 << 62;
    while (b > op) b >>= 2;
    while (b != 0) begin
      if (op >= res + b) begin
        op -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Q2.30 unit component, nearest with halves away from zero
  function automatic longint unit_q30(input longint num, input bit [63:0] len);
    bit [63:0] a, q;
    a = iabs(num);
    q = ((a << 30) + (len >> 1)) / len;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic force_t junction_force(
      input longint dx, input longint dy,
      input logic r_out, input logic [1:0] r_typ, input longint r_b,
      input logic l_out, input logic [1:0] l_typ, input longint l_b,
      input longint m_r, input longint m_l);
    force_t    res;
    longint    br, bl, thr, pr, pl, sr, sl, f, sx, sy, ux, uy;
    bit [63:0] ax, ay, mx, len;
    res.zero = 0;
    if (dx == 0 && dy == 0) begin
      res.fx = 0;
      res.fy = 0;
      res.zero = 1;
      return res;
    end
    // coefficient select and small-coefficient cut, right side first
    if (use_table) begin
      br = r_out ? 0 : longint'(beta_tab[r_typ]);
      bl = l_out ? 0 : longint'(beta_tab[l_typ]);
    end else begin
      br = r_out ? 0 : r_b;
      bl = l_out ? 0 : l_b;
    end
    thr = longint'(thresh);
    if (iabs(br) < thr) bl = 0;
    if (iabs(bl) < thr) br = 0;
    if (sym_myo) begin
      m_r -= 32768;
      m_l -= 32768;
    end
    // scalar force, exact products, difference rounded half up
    pr = br * m_r + 32768;
    pl = bl * m_l;
    sr = pr >>> 16;
    sl = pl >>> 16;
    f = sr - sl - ((pr[15:0] < pl[15:0]) ? 1 : 0);
    f = sat_q(f);
    // normalize the edge and build the rotated unit vector
    sx = dx;
    sy = dy;
    ax = iabs(sx);
    ay = iabs(sy);
    mx = (ax > ay) ? ax : ay;
    while (mx < (64'd1 << 30)) begin
      sx *= 2; sy *= 2; ax <<= 1; ay <<= 1; mx <<= 1;
    end
    len = root_floor(ax * ax + ay * ay);
    ux = unit_q30(-sy, len);
    uy = unit_q30(sx, len);
    res.fx = Q_W'(sat_q((f * ux + (64'sd1 <<< 29)) >>> 30));
    res.fy = Q_W'(sat_q((f * uy + (64'sd1 <<< 29)) >>> 30));
    return res;
  endfunction

  task automatic report(input string what, input logic [Q_W-1:0] got,
                        input logic [Q_W-1:0] want);
    $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    force_t e;
    if (!rst_n) begin
      use_table <= 0;
      sym_myo <= 0;
      thresh <= 1;
      for (int i = 0; i < 4; i++) beta_tab[i] <= 0;
      force_q.delete();
      fail_count <= 0;
      pending <= 0;
      n_checked <= 0;
      n_zero_edge <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_USE_TABLE: use_table <= cfg_data[0];
          CFG_SYM_MYO:   sym_myo <= cfg_data[0];
          CFG_THRESHOLD: thresh <= cfg_data[THR_W-1:0];
          CFG_BETA_T0:   beta_tab[0] <= cfg_data;
          CFG_BETA_T1:   beta_tab[1] <= cfg_data;
          CFG_BETA_T2:   beta_tab[2] <= cfg_data;
          CFG_BETA_T3:   beta_tab[3] <= cfg_data;
          default: ;
        endcase
      end
      // input transfer: predict
      if (in_ch.valid && in_ch.ready) begin
        e = junction_force(in_ch.edge_dx, in_ch.edge_dy,
                           in_ch.right_outer, in_ch.right_type, in_ch.right_beta,
                           in_ch.left_outer, in_ch.left_type, in_ch.left_beta,
                           in_ch.myo_here, in_ch.myo_pair);
        force_q.push_back(e);
        if (e.zero) n_zero_edge <= n_zero_edge + 1;
      end
      // output transfer: compare with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (force_q.size() == 0) begin
          report("unexpected transfer", {out_ch.force_x}, '0);
        end else begin
          e = force_q.pop_front();
          if (out_ch.force_x !== e.fx) report("force_x", out_ch.force_x, e.fx);
          if (out_ch.force_y !== e.fy) report("force_y", out_ch.force_y, e.fy);
          if (out_ch.zero_edge !== e.zero)
            report("zero_edge", {31'd0, out_ch.zero_edge}, {31'd0, e.zero});
        end
        n_checked <= n_checked + 1;
      end
      pending <= force_q.size();
    end
  end

endmodule

[verif/junction_active_area_force_test.sv]
`timescale 1ns / 100ps

module junction_active_area_force_test;
  import jaaf_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 2000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [Q_W-1:0]       cfg_data;

  int fail_count, pending, n_checked, n_zero_edge;
  int n_sent;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;

  jaaf_in_if  in_ch ();
  jaaf_out_if out_ch ();

  junction_active_area_force i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  junction_active_area_force_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .n_checked   (n_checked),
    .n_zero_edge (n_zero_edge)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Q16.16 value biased toward extremes, zero and small magnitudes
  function automatic logic [31:0] pick_q();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom_range(32'h3ffff) - 32'h20000;
      4: return 32'h0000_8000 + $urandom_range(32'hffff) - 32'h8000;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic tab, input logic sym, input logic [31:0] thr,
                            input logic [31:0] b0, input logic [31:0] b1,
                            input logic [31:0] b2, input logic [31:0] b3);
    write_reg(CFG_USE_TABLE, {31'd0, tab});
    write_reg(CFG_SYM_MYO, {31'd0, sym});
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_BETA_T0, b0);
    write_reg(CFG_BETA_T1, b1);
    write_reg(CFG_BETA_T2, b2);
    write_reg(CFG_BETA_T3, b3);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // idle pattern follows how far the run has got
  task automatic send_junction(input logic [31:0] dx, input logic [31:0] dy,
                               input logic ro, input logic [1:0] rt, input logic [31:0] rb,
                               input logic lo, input logic [1:0] lt, input logic [31:0] lb,
                               input logic [31:0] mh, input logic [31:0] mp);
    if (n_sent < 180) begin
      send_idle_pct = 20; recv_idle_pct = 83;
    end else if (n_sent < 360) begin
      send_idle_pct = 83; recv_idle_pct = 20;
    end else begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.edge_dx <= dx;
    in_ch.edge_dy <= dy;
    in_ch.right_outer <= ro;
    in_ch.right_type <= rt;
    in_ch.right_beta <= rb;
    in_ch.left_outer <= lo;
    in_ch.left_type <= lt;
    in_ch.left_beta <= lb;
    in_ch.myo_here <= mh;
    in_ch.myo_pair <= mp;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  task automatic send_random();
    logic [31:0] dx, dy;
    case ($urandom_range(9))
      0: begin dx = 0; dy = 0; end
      1: begin dx = 0; dy = pick_q(); end
      2: begin dx = pick_q(); dy = 0; end
      3: begin dx = $urandom_range(3) - 1; dy = $urandom_range(3) - 1; end
      default: begin dx = pick_q(); dy = pick_q(); end
    endcase
    send_junction(dx, dy, ($urandom_range(5) == 0), 2'($urandom_range(3)), pick_q(),
                  ($urandom_range(5) == 0), 2'($urandom_range(3)), pick_q(),
                  pick_q(), pick_q());
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.edge_dx = '0;
    in_ch.edge_dy = '0;
    in_ch.right_outer = 1'b0;
    in_ch.right_type = '0;
    in_ch.right_beta = '0;
    in_ch.left_outer = 1'b0;
    in_ch.left_type = '0;
    in_ch.left_beta = '0;
    in_ch.myo_here = '0;
    in_ch.myo_pair = '0;
    out_ch.ready = 1'b0;
    n_sent = 0;
    send_idle_pct = 20;
    recv_idle_pct = 83;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset configuration, per-cell coefficients
    send_junction(0, 0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000);
    send_junction(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 32'h20000, 32'h10000, 32'h10000);
    send_junction(0, 32'h10000, 0, 1, 32'h7fffffff, 0, 2, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff);
    send_junction(32'h80000000, 32'h80000000, 0, 0, 32'h80000000, 0, 0, 32'h7fffffff,
                  32'h80000000, 32'h7fffffff);
    send_junction(32'h7fffffff, 32'h80000000, 1, 3, 32'h7fffffff, 0, 0, 32'h10000,
                  32'h7fffffff, 32'h10000);
    send_junction(1, 0, 0, 0, 32'h80000000, 1, 3, 32'h7fffffff, 32'h80000000, 32'h0);
    send_junction(32'hffffffff, 1, 1, 0, 32'h10000, 1, 0, 32'h10000, 32'h10000, 32'h10000);
    send_junction(3, 4, 0, 0, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000);
    send_junction(32'h30000, 32'hfffc0000, 0, 0, 32'h18000, 0, 0, 1, 32'h8000, 32'h8000);
    send_junction(32'h00ff00ff, 32'h7fffffff, 0, 0, 32'h7fffffff, 0, 0, 32'h7fffffff,
                  32'h80000000, 32'h7fffffff);
    drain();

    // table coefficients, centered myosin, no threshold, extreme table
    set_config(1, 1, 0, 32'h80000000, 32'h7fffffff, 32'h10000, 32'hfffffffd);
    for (int t = 0; t < 4; t++)
      send_junction(32'h10000, 32'h10000, 0, 2'(t), 0, 0, 2'(3 - t), 0,
                    32'h8000, 32'h7fffffff);
    send_junction(32'h80000000, 0, 0, 0, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff);
    send_junction(0, 32'h7fffffff, 0, 1, 0, 1, 1, 0, 32'h7fffffff, 32'h80000000);
    repeat (90) send_random();
    drain();

    // per-cell coefficients, largest threshold
    set_config(0, 0, 32'h7fffffff, $urandom, $urandom, $urandom, $urandom);
    send_junction(32'h10000, 0, 0, 0, 32'h7fffffff, 0, 0, 32'h80000000,
                  32'h7fffffff, 32'h10000);
    send_junction(32'h10000, 0, 0, 0, 32'h7ffffffe, 0, 0, 32'h7fffffff,
                  32'h7fffffff, 32'h10000);
    repeat (90) send_random();
    drain();

    // table, plain myosin, threshold of one
    set_config(1, 0, 32'h10000, $urandom, $urandom, pick_q(), pick_q());
    repeat (100) send_random();
    drain();

    // per-cell, centered myosin, small threshold
    set_config(0, 1, $urandom_range(255), pick_q(), pick_q(), pick_q(), pick_q());
    repeat (100) send_random();
    drain();

    // mixed settings
    set_config(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, $urandom,
               $urandom, $urandom, $urandom);
    repeat (110) send_random();
    drain();

    $display("covered %0d junctions over six register settings, %0d of them zero-length",
             n_checked, n_zero_edge);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
